FILE: design/bsab_pkg.sv
package bsab_pkg;

  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 16'h7fff;
  localparam logic [PIX_W-1:0] PIX_MIN = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_BLOCK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BLOCK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 3'd5;

  // per-block command flags sent from front to back
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic eol;
    logic eof;
  } bsab_flags_t;

  localparam int FLAGS_W = $bits(bsab_flags_t);

  typedef enum logic [1:0] {
    RES_IDLE,
    RES_DIV,
    RES_HOLD
  } bsab_res_e;

endpackage

FILE: design/block_sum_average_binner_unit.sv
// Sum mode: a block's closing pixel passes the block queue, the read-modify-write stage and
// the output register before its result is valid; average mode adds the bit-serial divider.
// Throughput: one pixel per cycle while the queue has room. In average mode a new division
// cannot start until the previous quotient has been loaded into the output register; a 4-entry block queue
// absorbs bursts and the pixel input stalls when it fills.
// Reset: asynchronous, active low; registers return to defaults, counters clear.
module block_sum_average_binner_unit #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_BLOCK     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsab_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bsab_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [bsab_pkg::PIX_W-1:0] pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bsab_pkg::PIX_W-1:0] out_value_o,
  output logic                              end_of_line_o,
  output logic                              end_of_frame_o
);

  localparam int CMD_W = bsab_pkg::PIX_W + $clog2(MAX_BLOCK) + $clog2(MAX_OUT_WIDTH)
                         + bsab_pkg::FLAGS_W;
  localparam int BSQ_W = 2 * ($clog2(MAX_BLOCK) + 1);

  logic             q_full, q_push, q_pop, q_valid, avg_mode;
  logic [CMD_W-1:0] q_in_data, q_out_data;
  logic [BSQ_W-1:0] bsq;

  bsab_front #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in_data),
    .avg_mode_o (avg_mode),
    .bsq_o      (bsq)
  );

  bsab_queue #(
    .DATA_W(CMD_W),
    .DEPTH (bsab_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_out_data)
  );

  bsab_back #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_data_i     (q_out_data),
    .cmd_pop_o      (q_pop),
    .avg_mode_i     (avg_mode),
    .bsq_i          (bsq),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_value_o    (out_value_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

FILE: design/bsab_front.sv
module bsab_front #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_BLOCK     = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bsab_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bsab_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [bsab_pkg::PIX_W-1:0]     pixel_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output logic [bsab_pkg::PIX_W+$clog2(MAX_BLOCK)+$clog2(MAX_OUT_WIDTH)
                +bsab_pkg::FLAGS_W-1:0]         q_data_o,
  output logic                                  avg_mode_o,
  output logic [2*($clog2(MAX_BLOCK)+1)-1:0]    bsq_o
);

  localparam int BLK_W = $clog2(MAX_BLOCK) + 1;
  localparam int COL_W = $clog2(MAX_OUT_WIDTH);
  localparam int OW_W  = COL_W + 1;
  localparam int ACT_W = OW_W + BLK_W;
  localparam int IC_W  = (ACT_W > bsab_pkg::CFG_DATA_W) ? ACT_W : bsab_pkg::CFG_DATA_W;
  localparam int OH_W  = bsab_pkg::CFG_DATA_W;
  localparam int RS_W  = bsab_pkg::PIX_W + $clog2(MAX_BLOCK);
  localparam int BSQ_W = 2 * BLK_W;

  logic [14:0] in_width_q;
  logic [10:0] out_width_q;
  logic [14:0] out_height_q;
  logic [4:0]  x_block_q;
  logic [4:0]  y_block_q;
  logic        avg_q;

  logic [BLK_W-1:0] xb_eff, yb_eff;
  logic [OW_W-1:0]  ow_eff;
  logic [OH_W-1:0]  oh_eff;
  logic [ACT_W-1:0] active;
  logic [IC_W-1:0]  iw_eff;

  logic [IC_W-1:0]  ic_q, ic_d, ic_next;
  logic [BLK_W-1:0] bx_q, bx_d;
  logic [OW_W-1:0]  oc_q, oc_d;
  logic [BLK_W-1:0] by_q, by_d, by_next;
  logic [OH_W-1:0]  orow_q, orow_d;
  logic signed [RS_W-1:0] rs_q, rs_d, rs_sum;

  logic accept, frame_done, in_blocks, blk_end;
  bsab_pkg::bsab_flags_t flags;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= 15'd1024;
      out_width_q  <= 11'd64;
      out_height_q <= 15'd64;
      x_block_q    <= 5'd16;
      y_block_q    <= 5'd16;
      avg_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsab_pkg::REG_IN_WIDTH:     in_width_q   <= cfg_data_i;
        bsab_pkg::REG_OUT_WIDTH:    out_width_q  <= cfg_data_i[10:0];
        bsab_pkg::REG_OUT_HEIGHT:   out_height_q <= cfg_data_i;
        bsab_pkg::REG_X_BLOCK:      x_block_q    <= cfg_data_i[4:0];
        bsab_pkg::REG_Y_BLOCK:      y_block_q    <= cfg_data_i[4:0];
        bsab_pkg::REG_AVERAGE_MODE: avg_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp the factors and sizes into their working ranges
  always_comb begin
    if (x_block_q == '0)                xb_eff = BLK_W'(1);
    else if (32'(x_block_q) > MAX_BLOCK) xb_eff = BLK_W'(MAX_BLOCK);
    else                                 xb_eff = BLK_W'(x_block_q);

    if (y_block_q == '0)                yb_eff = BLK_W'(1);
    else if (32'(y_block_q) > MAX_BLOCK) yb_eff = BLK_W'(MAX_BLOCK);
    else                                 yb_eff = BLK_W'(y_block_q);

    if (out_width_q == '0)                   ow_eff = OW_W'(1);
    else if (32'(out_width_q) > MAX_OUT_WIDTH) ow_eff = OW_W'(MAX_OUT_WIDTH);
    else                                       ow_eff = OW_W'(out_width_q);

    oh_eff = (out_height_q == '0) ? OH_W'(1) : out_height_q;
    active = ACT_W'(ow_eff) * ACT_W'(xb_eff);
    iw_eff = (IC_W'(in_width_q) < IC_W'(active)) ? IC_W'(active) : IC_W'(in_width_q);
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign frame_done = (orow_q >= oh_eff);
  assign in_blocks  = (ic_q < IC_W'(active)) && (oc_q < ow_eff);
  assign blk_end    = (BLK_W'(bx_q + 1'b1) >= xb_eff);
  assign rs_sum     = rs_q + RS_W'(pixel_i);
  assign ic_next    = IC_W'(ic_q + 1'b1);
  assign by_next    = BLK_W'(by_q + 1'b1);

  always_comb begin
    flags.first_row = (by_q == '0);
    flags.last_row  = (by_next >= yb_eff);
    flags.eol       = (OW_W'(oc_q + 1'b1) == ow_eff);
    flags.eof       = flags.eol && (OH_W'(orow_q + 1'b1) == oh_eff);
  end

  assign q_data_o = {rs_sum, oc_q[COL_W-1:0], flags};

  always_comb begin
    ic_d     = ic_q;
    bx_d     = bx_q;
    oc_d     = oc_q;
    by_d     = by_q;
    orow_d   = orow_q;
    rs_d     = rs_q;
    q_push_o = 1'b0;
    if (cfg_we_i) begin
      // any register write restarts the frame
      ic_d   = '0;
      bx_d   = '0;
      oc_d   = '0;
      by_d   = '0;
      orow_d = '0;
      rs_d   = '0;
    end else if (accept && !frame_done) begin
      if (in_blocks) begin
        if (blk_end) begin
          q_push_o = 1'b1;
          rs_d     = '0;
          bx_d     = '0;
          oc_d     = OW_W'(oc_q + 1'b1);
        end else begin
          rs_d = rs_sum;
          bx_d = BLK_W'(bx_q + 1'b1);
        end
      end
      if (ic_next >= iw_eff) begin
        ic_d = '0;
        bx_d = '0;
        oc_d = '0;
        rs_d = '0;
        if (by_next >= yb_eff) begin
          by_d   = '0;
          orow_d = OH_W'(orow_q + 1'b1);
        end else begin
          by_d = by_next;
        end
      end else begin
        ic_d = ic_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q   <= '0;
      bx_q   <= '0;
      oc_q   <= '0;
      by_q   <= '0;
      orow_q <= '0;
      rs_q   <= '0;
    end else begin
      ic_q   <= ic_d;
      bx_q   <= bx_d;
      oc_q   <= oc_d;
      by_q   <= by_d;
      orow_q <= orow_d;
      rs_q   <= rs_d;
    end
  end

  assign avg_mode_o = avg_q;
  assign bsq_o      = BSQ_W'(xb_eff) * BSQ_W'(yb_eff);

endmodule

FILE: design/bsab_queue.sv
module bsab_queue #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_q + 1'b1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_q + 1'b1);
      end
      if (do_push && !do_pop)      count_q <= CNT_W'(count_q + 1'b1);
      else if (do_pop && !do_push) count_q <= CNT_W'(count_q - 1'b1);
    end
  end

endmodule

FILE: design/bsab_back.sv
module bsab_back #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_BLOCK     = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  logic [bsab_pkg::PIX_W+$clog2(MAX_BLOCK)+$clog2(MAX_OUT_WIDTH)
                +bsab_pkg::FLAGS_W-1:0]         cmd_data_i,
  output logic                                  cmd_pop_o,
  input  logic                                  avg_mode_i,
  input  logic [2*($clog2(MAX_BLOCK)+1)-1:0]    bsq_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bsab_pkg::PIX_W-1:0]     out_value_o,
  output logic                                  end_of_line_o,
  output logic                                  end_of_frame_o
);

  localparam int PIX_W = bsab_pkg::PIX_W;
  localparam int FLG_W = bsab_pkg::FLAGS_W;
  localparam int BLK_W = $clog2(MAX_BLOCK) + 1;
  localparam int COL_W = $clog2(MAX_OUT_WIDTH);
  localparam int RS_W  = PIX_W + $clog2(MAX_BLOCK);
  localparam int SUM_W = PIX_W + 2 * $clog2(MAX_BLOCK);
  localparam int N_W   = SUM_W + 1;
  localparam int BSQ_W = 2 * BLK_W;
  localparam int CNT_W = $clog2(N_W + 1);
  localparam int CMD_W = RS_W + COL_W + FLG_W;

  // head of the queue
  logic signed [RS_W-1:0] cmd_sum;
  logic [COL_W-1:0]       cmd_col;
  bsab_pkg::bsab_flags_t  cmd_flags;

  assign cmd_sum   = cmd_data_i[CMD_W-1 -: RS_W];
  assign cmd_col   = cmd_data_i[FLG_W +: COL_W];
  assign cmd_flags = bsab_pkg::bsab_flags_t'(cmd_data_i[FLG_W-1:0]);

  // line accumulator
  logic signed [SUM_W-1:0] acc_mem [MAX_OUT_WIDTH];
  logic signed [SUM_W-1:0] rdata_q;

  // read-modify-write stage
  logic                    r_valid_q;
  logic signed [RS_W-1:0]  r_sum_q;
  logic [COL_W-1:0]        r_col_q;
  bsab_pkg::bsab_flags_t   r_flags_q;
  logic                    r_fwd_q;
  logic signed [SUM_W-1:0] wr_total_q;
  logic signed [SUM_W-1:0] prev_sum, total;

  // result unit
  bsab_pkg::bsab_res_e     state_q, state_d;
  logic [BSQ_W-1:0]        div_rem_q;
  logic [N_W-1:0]          div_quo_q;
  logic [CNT_W-1:0]        div_cnt_q;
  logic                    div_neg_q;
  logic                    res_eol_q, res_eof_q;

  logic out_free, post_ready, r_go, pop;
  logic out_load, out_load_eol, out_load_eof, div_start, div_step;
  logic signed [PIX_W-1:0] out_load_val;
  logic signed [PIX_W-1:0] sat_total, sat_quo;

  logic signed [N_W-1:0]   half_s, numer;
  logic [N_W-1:0]          numer_mag;
  logic [BSQ_W:0]          trial;
  logic                    trial_ge;
  logic signed [N_W:0]     quo_s;
  logic [SUM_W-PIX_W:0]    total_hi;
  logic [N_W-PIX_W+1:0]    quo_hi;

  logic                    out_valid_q;
  logic signed [PIX_W-1:0] out_value_q;
  logic                    out_eol_q, out_eof_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // back-to-back updates of one column bypass the memory
  assign prev_sum = r_flags_q.first_row ? '0 : (r_fwd_q ? wr_total_q : rdata_q);
  assign total    = SUM_W'(r_sum_q) + prev_sum;

  assign total_hi  = total[SUM_W-1:PIX_W-1];
  assign sat_total = ((&total_hi) || !(|total_hi)) ? total[PIX_W-1:0] :
                     (total[SUM_W-1] ? bsab_pkg::PIX_MIN : bsab_pkg::PIX_MAX);

  // rounded average: (total + half) / bsq, truncated toward zero
  assign half_s    = N_W'(bsq_i >> 1);
  assign numer     = N_W'(total) + half_s;
  assign numer_mag = numer[N_W-1] ? N_W'(-numer) : N_W'(numer);

  assign trial    = {div_rem_q, div_quo_q[N_W-1]};
  assign trial_ge = (trial >= {1'b0, bsq_i});

  assign quo_s   = div_neg_q ? -$signed({1'b0, div_quo_q}) : $signed({1'b0, div_quo_q});
  assign quo_hi  = quo_s[N_W:PIX_W-1];
  assign sat_quo = ((&quo_hi) || !(|quo_hi)) ? quo_s[PIX_W-1:0] :
                   (quo_s[N_W] ? bsab_pkg::PIX_MIN : bsab_pkg::PIX_MAX);

  // result unit outputs
  always_comb begin
    post_ready   = 1'b0;
    out_load     = 1'b0;
    out_load_val = sat_total;
    out_load_eol = r_flags_q.eol;
    out_load_eof = r_flags_q.eof;
    div_start    = 1'b0;
    div_step     = 1'b0;
    unique case (state_q)
      bsab_pkg::RES_IDLE: begin
        post_ready = avg_mode_i || out_free;
      end
      bsab_pkg::RES_DIV: begin
        div_step = 1'b1;
      end
      bsab_pkg::RES_HOLD: begin
        out_load     = out_free;
        out_load_val = sat_quo;
        out_load_eol = res_eol_q;
        out_load_eof = res_eof_q;
      end
      default: ;
    endcase
    r_go = r_valid_q && (!r_flags_q.last_row || post_ready);
    if (state_q == bsab_pkg::RES_IDLE && r_go && r_flags_q.last_row) begin
      if (avg_mode_i) div_start = 1'b1;
      else            out_load  = 1'b1;
    end
  end

  // result unit next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsab_pkg::RES_IDLE: if (div_start) state_d = bsab_pkg::RES_DIV;
      bsab_pkg::RES_DIV:  if (div_cnt_q == CNT_W'(1)) state_d = bsab_pkg::RES_HOLD;
      bsab_pkg::RES_HOLD: if (out_free) state_d = bsab_pkg::RES_IDLE;
      default:            state_d = bsab_pkg::RES_IDLE;
    endcase
  end

  assign pop       = cmd_valid_i && (!r_valid_q || r_go);
  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i) begin
    if (r_go) acc_mem[r_col_q] <= total;
    if (pop)  rdata_q <= acc_mem[cmd_col];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      state_q     <= bsab_pkg::RES_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop)       r_valid_q <= 1'b1;
      else if (r_go) r_valid_q <= 1'b0;
      state_q <= state_d;
      if (div_start)     div_cnt_q <= CNT_W'(N_W);
      else if (div_step) div_cnt_q <= CNT_W'(div_cnt_q - 1'b1);
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      r_sum_q   <= cmd_sum;
      r_col_q   <= cmd_col;
      r_flags_q <= cmd_flags;
      r_fwd_q   <= r_valid_q && (r_col_q == cmd_col);
    end
    if (r_go) wr_total_q <= total;
    if (div_start) begin
      div_quo_q <= numer_mag;
      div_rem_q <= '0;
      div_neg_q <= numer[N_W-1];
      res_eol_q <= r_flags_q.eol;
      res_eof_q <= r_flags_q.eof;
    end else if (div_step) begin
      div_rem_q <= trial_ge ? BSQ_W'(trial - {1'b0, bsq_i}) : trial[BSQ_W-1:0];
      div_quo_q <= {div_quo_q[N_W-2:0], trial_ge};
    end
    if (out_load) begin
      out_value_q <= out_load_val;
      out_eol_q   <= out_load_eol;
      out_eof_q   <= out_load_eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign end_of_line_o  = out_eol_q;
  assign end_of_frame_o = out_eof_q;

endmodule

FILE: design/bsab_checker.sv
module bsab_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_i,
  input logic                              out_valid_i,
  input logic                              out_stall_i,
  input logic signed [bsab_pkg::PIX_W-1:0] out_value_i,
  input logic                              eol_i,
  input logic                              eof_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_value_i) &&
                                   $stable(eol_i) && $stable(eof_i))
    else $error("stalled result changed");

  // frame end always closes a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && eof_i |-> eol_i)
    else $error("end of frame without end of line");

  // no result right out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  // queue starts empty, so the pixel input is open after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_stall_i)
    else $error("input stalled right after reset");

endmodule

bind block_sum_average_binner_unit bsab_checker u_bsab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_value_i (out_value_o),
  .eol_i       (end_of_line_o),
  .eof_i       (end_of_frame_o)
);
